### hw/rtl/fyp_pkg.sv
// Shared constants for the Fisher-Yates permutation generator.
// No dependencies; imported by fisher_yates_permutation_generator_core.
package fyp_pkg;

  // Field widths of the channels and the row count register
  localparam int CNT_W  = 11;
  localparam int IDX_W  = 10;
  localparam int WORD_W = 32;

  // Width of the epoch tag kept beside each store entry
  localparam int EP_W   = 8;

  // Default store depth
  localparam int DEF_MAX_ROWS = 1024;

  // Operation codes of an input item
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

endpackage

### hw/rtl/fisher_yates_permutation_generator_core.sv
// Fisher-Yates permutation generator core: sequencer, bit-serial divider, store.
// Depends on fyp_pkg.
//
// Usage:
//   cfg_wr_en/cfg_wr_data write the row count (saturated to MAX_ROWS); write it
//   only while no item is in flight.
//   Input items: in_operation OP_START begins a new permutation (identity, position 0);
//   OP_STEP carries one random word and performs one swap. An item is taken when
//   in_valid is high and in_stall is low. in_stall stays high while an item is worked.
//   Results: out_valid/out_stall with out_position, out_source_index, out_last. A step
//   not ignored yields one result; the one at position count-2 adds a second, marked last.
//   A start with a count of one yields position 0 marked last.
// Step sequence:
//   A step is accepted in idle, then runs the bit-serial remainder unit (random word
//   mod remaining span), two reads on the registered store port (S_RDI, S_RDJ, S_CAPB),
//   two writes (S_WRI, S_WRJ), and loads the result in S_EMIT0 once the output is free.
//   The step at position count-2 adds the final read (S_RDL) and its result (S_EMIT1).
//   A start or an ignored step ends in idle; a start with a count of one adds S_EMITS.
// Reset and stall:
//   After reset the store tags are swept, one entry a cycle, over all MAX_ROWS entries;
//   no item is taken meanwhile. The same sweep runs after every 255th start, when the
//   epoch tag wraps. A stalled result holds in the output register; the sequencer
//   waits for it to be taken before loading the next result.
module fisher_yates_permutation_generator_core
  import fyp_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [WORD_W-1:0] in_random_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_position,
  output logic [IDX_W-1:0]  out_source_index,
  output logic              out_last
);

  localparam int AW    = $clog2(MAX_ROWS);
  localparam int ENT_W = EP_W + IDX_W;
  localparam int DC_W  = $clog2(WORD_W);
  localparam logic [EP_W-1:0] EP_MAX   = '1;
  localparam logic [DC_W-1:0] DIV_LAST = DC_W'(WORD_W - 1);
  localparam logic [AW-1:0]   CLR_LAST = AW'(MAX_ROWS - 1);

  // Sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RDI   = 4'd3;
  localparam logic [3:0] S_RDJ   = 4'd4;
  localparam logic [3:0] S_CAPB  = 4'd5;
  localparam logic [3:0] S_WRI   = 4'd6;
  localparam logic [3:0] S_WRJ   = 4'd7;
  localparam logic [3:0] S_EMIT0 = 4'd8;
  localparam logic [3:0] S_RDL   = 4'd9;
  localparam logic [3:0] S_EMIT1 = 4'd10;
  localparam logic [3:0] S_EMITS = 4'd11;

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  row_count_r;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  span_r, span_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [DC_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [EP_W-1:0]   epoch_r, epoch_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]  a_r, a_nxt;
  logic [IDX_W-1:0]  b_r, b_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_pos_r, out_pos_nxt;
  logic [IDX_W-1:0]  out_src_r, out_src_nxt;
  logic              out_last_r, out_last_nxt;

  logic [CNT_W-1:0]  eff_cnt;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [CNT_W:0]    trial;
  logic              out_free;
  logic              in_take;

  logic [ENT_W-1:0]  mem [MAX_ROWS];
  logic [ENT_W-1:0]  rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  // Entry with a stale tag reads as its own index
  function automatic logic [IDX_W-1:0] resolve(input logic [ENT_W-1:0] ent,
                                               input logic [CNT_W-1:0] idx,
                                               input logic [EP_W-1:0]  ep);
    resolve = (ent[ENT_W-1:IDX_W] == ep) ? ent[IDX_W-1:0] : idx[IDX_W-1:0];
  endfunction

  // Saturate the row count to the store depth
  assign eff_cnt  = (32'(row_count_r) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : row_count_r;
  assign cnt_m1   = eff_cnt - CNT_W'(1);
  assign cnt_m2   = eff_cnt - CNT_W'(2);
  assign trial    = {rem_r, word_r[WORD_W-1]};
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && (state_r == S_IDLE);

  // Sequencer, divider step and output load
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    span_nxt      = span_r;
    rem_nxt       = rem_r;
    j_nxt         = j_r;
    word_nxt      = word_r;
    div_cnt_nxt   = div_cnt_r;
    epoch_nxt     = epoch_r;
    clr_cnt_nxt   = clr_cnt_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pos_nxt   = out_pos_r;
    out_src_nxt   = out_src_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(pos_r);
    mem_wdata     = {epoch_r, b_r};
    mem_re        = 1'b0;
    mem_raddr     = AW'(pos_r);

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          clr_cnt_nxt = '0;
          epoch_nxt   = EP_W'(1);
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          if (in_operation == OP_START) begin
            pos_nxt = '0;
            if (eff_cnt == CNT_W'(1)) begin
              state_nxt = S_EMITS;
            end else if (epoch_r == EP_MAX) begin
              state_nxt = S_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EP_W'(1);
            end
          end else if (eff_cnt >= CNT_W'(2) && pos_r < cnt_m1) begin
            span_nxt    = eff_cnt - pos_r;
            rem_nxt     = '0;
            word_nxt    = in_random_word;
            div_cnt_nxt = '0;
            state_nxt   = S_DIV;
          end
        end
      end
      S_DIV: begin
        // One restoring remainder step per cycle
        if (trial >= {1'b0, span_r}) begin
          rem_nxt = CNT_W'(trial - {1'b0, span_r});
        end else begin
          rem_nxt = trial[CNT_W-1:0];
        end
        word_nxt    = {word_r[WORD_W-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + DC_W'(1);
        if (div_cnt_r == DIV_LAST) begin
          j_nxt     = pos_r + rem_nxt;
          state_nxt = S_RDI;
        end
      end
      S_RDI: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(pos_r);
        state_nxt = S_RDJ;
      end
      S_RDJ: begin
        a_nxt     = resolve(rd_data_r, pos_r, epoch_r);
        mem_re    = 1'b1;
        mem_raddr = AW'(j_r);
        state_nxt = S_CAPB;
      end
      S_CAPB: begin
        b_nxt     = resolve(rd_data_r, j_r, epoch_r);
        state_nxt = S_WRI;
      end
      S_WRI: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r);
        mem_wdata = {epoch_r, b_r};
        state_nxt = S_WRJ;
      end
      S_WRJ: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j_r);
        mem_wdata = {epoch_r, a_r};
        state_nxt = S_EMIT0;
      end
      S_EMIT0: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r[IDX_W-1:0];
          out_src_nxt   = b_r;
          out_last_nxt  = 1'b0;
          pos_nxt       = pos_r + CNT_W'(1);
          state_nxt     = (pos_r == cnt_m2) ? S_RDL : S_IDLE;
        end
      end
      S_RDL: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(cnt_m1);
        state_nxt = S_EMIT1;
      end
      S_EMIT1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = cnt_m1[IDX_W-1:0];
          out_src_nxt   = resolve(rd_data_r, cnt_m1, epoch_r);
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_EMITS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = '0;
          out_src_nxt   = '0;
          out_last_nxt  = 1'b1;
          if (epoch_r == EP_MAX) begin
            state_nxt = S_CLEAR;
          end else begin
            epoch_nxt = epoch_r + EP_W'(1);
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_count_r <= '0;
      pos_r       <= '0;
      epoch_r     <= EP_W'(1);
      clr_cnt_r   <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      epoch_r     <= epoch_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        row_count_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    span_r     <= span_nxt;
    rem_r      <= rem_nxt;
    j_r        <= j_nxt;
    word_r     <= word_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    out_pos_r  <= out_pos_nxt;
    out_src_r  <= out_src_nxt;
    out_last_r <= out_last_nxt;
  end

  // Permutation store with epoch tags: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_pos_r;
  assign out_source_index = out_src_r;
  assign out_last         = out_last_r;

`ifndef SYNTH
  // Remainder stays below the span throughout the division
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < span_r))
    else $error("remainder reached span");

  // Swap partner lies between the position and the count
  a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDI) |-> (j_r >= pos_r && j_r < eff_cnt))
    else $error("swap index out of range");

  // Division runs its full length before the store is touched
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r != DIV_LAST) |=> (state_r == S_DIV))
    else $error("division left early");

  // A new result never overwrites one still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_pos_r)
                                    && $stable(out_src_r)))
    else $error("stalled result overwritten");
`endif

endmodule

### dv/fisher_yates_permutation_generator_core_test.sv
`timescale 1ns / 1ps
// Testbench for fisher_yates_permutation_generator_core: directed and random permutations,
// each result checked against a behavioral model of the swap loop kept in this file.
// Depends on fyp_pkg and fisher_yates_permutation_generator_core.
module fisher_yates_permutation_generator_core_test;
  import fyp_pkg::*;

  localparam int ROWS             = DEF_MAX_ROWS;
  localparam int SETTLE_CYCLES    = 60;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int MAX_PRINTED      = 40;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  typedef struct packed {
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] source;
    logic             last;
  } row_result_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              cfg_wr_en      = 1'b0;
  logic [CNT_W-1:0]  cfg_wr_data    = '0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              in_operation   = OP_START;
  logic [WORD_W-1:0] in_random_word = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [IDX_W-1:0]  out_position;
  logic [IDX_W-1:0]  out_source_index;
  logic              out_last;

  // Model state: row count register, shuffle position, store with written marks
  int unsigned       row_count_q;
  int unsigned       shuffle_pos;
  logic [IDX_W-1:0]  row_store [ROWS];
  bit                row_written [ROWS];
  row_result_t       pending_rows [$];

  int                mismatches;
  int                work_items;
  int                burst_left;
  bit                sender_gaps;
  stall_mode_t       stall_mode = STALL_NONE;
  int                hold_requests;
  int                hold_served;
  int                hold_left;
  int                stall_phase;

  always #4 clk = ~clk;

  fisher_yates_permutation_generator_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_random_word   (in_random_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position     (out_position),
    .out_source_index (out_source_index),
    .out_last         (out_last)
  );

  // Unwritten entries read as their own index
  function automatic logic [IDX_W-1:0] read_row(int unsigned idx);
    return row_written[idx] ? row_store[idx] : IDX_W'(idx);
  endfunction

  function automatic void write_row(int unsigned idx, logic [IDX_W-1:0] value);
    row_store[idx]   = value;
    row_written[idx] = 1'b1;
  endfunction

  // Advance the model by one item and queue the rows it finalizes; 0 if ignored
  function automatic bit predict_rows(logic op, logic [WORD_W-1:0] word);
    int unsigned      n;
    int unsigned      i;
    int unsigned      j;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    n = (row_count_q > ROWS) ? ROWS : row_count_q;
    if (op == OP_START) begin
      foreach (row_written[k]) row_written[k] = 1'b0;
      shuffle_pos = 0;
      if (n == 1) pending_rows.push_back('{'0, '0, 1'b1});
      return 1'b1;
    end
    if (n < 2 || shuffle_pos >= n - 1) return 1'b0;
    i = shuffle_pos;
    j = i + word % (n - i);
    a = read_row(i);
    b = read_row(j);
    write_row(i, b);
    write_row(j, a);
    pending_rows.push_back('{IDX_W'(i), b, 1'b0});
    if (i == n - 2) pending_rows.push_back('{IDX_W'(n - 1), read_row(n - 1), 1'b1});
    shuffle_pos = i + 1;
    return 1'b1;
  endfunction

  // Mix of extremes, small values and full-range words
  function automatic logic [WORD_W-1:0] draw_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return WORD_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, what);
  endtask

  // Offer one item, with a random gap between bursts when enabled, and predict once taken
  task automatic send_item(input logic op, input logic [WORD_W-1:0] word);
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_random_word <= word;
    do @(posedge clk); while (in_stall);
    work_items += predict_rows(op, word);
  endtask

  // Drop valid, wait for every expected row, then let an ignored item finish
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_count(input int unsigned value);
    settle_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    row_count_q = value;
  endtask

  // Count zero at reset, then steps on the identity before any start
  task automatic test_before_start();
    stall_mode = STALL_PATTERN;
    send_item(OP_STEP, 32'h1234_5678);
    write_row_count(5);
    send_item(OP_STEP, '0);
    send_item(OP_STEP, '1);
    send_item(OP_STEP, 32'd7);
    send_item(OP_STEP, $urandom);
    send_item(OP_STEP, $urandom);
    write_row_count(0);
    send_item(OP_START, $urandom);
  endtask

  // Count of one emits a single last row; count of two swaps or keeps
  task automatic test_small_counts();
    write_row_count(1);
    send_item(OP_START, '0);
    send_item(OP_STEP, $urandom);
    write_row_count(2);
    send_item(OP_START, '1);
    send_item(OP_STEP, '1);
    send_item(OP_START, '0);
    send_item(OP_STEP, '0);
    send_item(OP_STEP, '1);
  endtask

  // Saturated count, far swaps, then retarget the count mid permutation
  task automatic test_saturation_and_retarget();
    stall_mode = STALL_RANDOM;
    write_row_count(2047);
    send_item(OP_START, '0);
    send_item(OP_STEP, '1);
    send_item(OP_STEP, 32'h8000_0000);
    send_item(OP_STEP, $urandom);
    write_row_count(1024);
    send_item(OP_STEP, 32'h7FFF_FFFF);
    write_row_count(6);
    send_item(OP_STEP, $urandom);
    send_item(OP_STEP, $urandom);
    write_row_count(3);
    send_item(OP_STEP, $urandom);
    write_row_count(9);
    send_item(OP_STEP, $urandom);
    send_item(OP_STEP, $urandom);
    send_item(OP_STEP, $urandom);
  endtask

  // Hold the output for a long stretch while the sender keeps offering
  task automatic test_long_hold();
    write_row_count(12);
    sender_gaps = 1'b0;
    stall_mode  = STALL_NONE;
    hold_requests++;
    send_item(OP_START, '0);
    repeat (11) send_item(OP_STEP, draw_word());
    settle_idle();
  endtask

  // Mostly whole permutations with random words; some broken or noisy ones
  task automatic test_random_permutations();
    int          pick;
    int          shape;
    int unsigned n;
    int unsigned steps;
    while (work_items < 1000) begin
      if ($urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)       write_row_count(0);
        else if (pick < 8)  write_row_count(1);
        else if (pick < 70) write_row_count($urandom_range(2, 12));
        else if (pick < 90) write_row_count($urandom_range(13, 64));
        else if (pick < 96) write_row_count($urandom_range(65, 1024));
        else                write_row_count($urandom_range(1025, 2047));
      end
      sender_gaps = ($urandom_range(0, 3) != 0);
      stall_mode  = stall_mode_t'($urandom_range(0, 2));
      n = (row_count_q > ROWS) ? ROWS : row_count_q;
      if (n > 64)      steps = $urandom_range(2, 24);
      else if (n >= 2) steps = n - 1;
      else             steps = $urandom_range(0, 2);
      shape = $urandom_range(0, 19);
      if (shape == 0) steps = $urandom_range(0, steps);
      if (shape == 1) steps += $urandom_range(1, 3);
      send_item(OP_START, $urandom);
      for (int k = 0; k < steps; k++) begin
        if (k == steps / 2 && shape == 2) send_item(OP_START, $urandom);
        if (k == steps / 2 && shape == 3) write_row_count($urandom_range(0, 40));
        if (shape == 4) send_item(logic'($urandom_range(0, 1)), draw_word());
        else            send_item(OP_STEP, draw_word());
      end
    end
  endtask

  // Receiver stall: long hold on request, else none, random or a fixed pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      stall_phase = (stall_phase + 1) % 7;
      case (stall_mode)
        STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PATTERN: out_stall <= (stall_phase < 3);
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  // Compare each taken result with the oldest expected row
  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected item pos=%0d src=%0d last=%0b",
                                  out_position, out_source_index, out_last));
      end else begin
        want = pending_rows.pop_front();
        if (out_position !== want.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    out_position, want.position));
        if (out_source_index !== want.source)
          report_mismatch($sformatf("source_index %0d, expected %0d at position %0d",
                                    out_source_index, want.source, want.position));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b at position %0d",
                                    out_last, want.last, want.position));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_before_start();
    test_small_counts();
    test_saturation_and_retarget();
    test_long_hold();
    test_random_permutations();
    settle_idle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
